FILE: design/bde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and constants for the button debounce event queue.
// ----------------------------------------------------------------------------
package bde_pkg;
  localparam logic [1:0] CMD_EDGE     = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_POP      = 2'd2;
  localparam logic [1:0] CMD_BASELINE = 2'd3;

  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_SHORT   = 2'd2;
  localparam logic [1:0] KIND_LONG    = 2'd3;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG     = 2'd1;
  localparam logic [1:0] REG_LEVEL    = 2'd2;

  localparam int MASK_BITS = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input transaction
    logic edge_arm;  // arm one debounce deadline
    logic baseline;  // reload stable states
    logic visit;     // evaluate the current button and stage its events
    logic push;      // push the head staged event
    logic pop_rd;    // issue a ring read
    logic pop_out;   // capture the ring read into the result
    logic step_btn;  // advance the button counter
  } bde_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pend;      // staged events remain
    logic last_btn;  // button counter is at the last button
    logic empty;     // ring is empty
  } bde_sts_t;
endpackage
`default_nettype wire

FILE: design/bde_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_ram
// Generic single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
module bde_ram #(
  parameter int WIDTH = 69,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

FILE: design/bde_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_datapath
// Per-button state, event staging, ring pointers and result register.
// ----------------------------------------------------------------------------
module bde_datapath #(
  parameter int BUTTONS     = 6,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [2:0]        in_button,
  input  wire logic [31:0]       in_now,
  input  wire logic [BUTTONS-1:0] in_pins,
  input  wire bde_pkg::bde_cmd_t cmd,
  output bde_pkg::bde_sts_t      sts,
  output logic [1:0]             cur_cmd,
  output logic [75:0]            result
);
  localparam int BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int MB = bde_pkg::MASK_BITS;

  logic [15:0] deb_r, lpt_r;
  logic        lvl_r;
  logic [1:0]  cmd_r;
  logic [2:0]  bidx_r;
  logic [31:0] now_r;
  logic [BUTTONS-1:0] pins_r;

  logic [BUTTONS-1:0] wait_r, down_r, lg_r;
  logic [31:0] dl_r [BUTTONS];
  logic [31:0] ps_r [BUTTONS];
  logic [BW-1:0] btn_r;

  // Up to three staged events of one button: kind per slot, shared hold.
  logic [2:0]  stg_v_r;
  logic [1:0]  stg_k_r [3];
  logic [31:0] stg_hold_r;
  logic [2:0]  stg_b_r;

  logic [QW-1:0] wp_r, rp_r;
  // Event fields of the result from bit 0: valid, button, kind, time, hold.
  logic [69:0] res_r;

  logic [31:0] dl, ps, hold, lt, dd, ld;
  logic        s, dueb;
  logic [QW-1:0] wp_n, rp_n;
  logic [68:0] rd;
  logic [1:0]  k0;
  logic [MB-1:0] mask;

  // Outcome of visiting the current button.
  logic        v_wait, v_down, v_lg, v_press;
  logic [2:0]  v_stg;
  logic [1:0]  v_k0, v_k1, v_k2;
  logic [31:0] v_hold;

  assign dl   = dl_r[btn_r];
  assign ps   = ps_r[btn_r];
  assign s    = (pins_r[btn_r] == lvl_r);
  assign hold = now_r - ps;
  assign lt   = {16'd0, lpt_r};
  assign wp_n = (wp_r == QW'(QUEUE_DEPTH-1)) ? '0 : wp_r + 1'b1;
  assign rp_n = (rp_r == QW'(QUEUE_DEPTH-1)) ? '0 : rp_r + 1'b1;
  assign k0   = stg_v_r[0] ? stg_k_r[0] : (stg_v_r[1] ? stg_k_r[1] : stg_k_r[2]);
  assign dd   = now_r - dl;
  assign dueb = wait_r[btn_r] && !dd[31];
  assign ld   = now_r - (ps + lt);

  always_comb begin
    mask = '0;
    for (int i = 0; i < BUTTONS && i < MB; i++) mask[i] = down_r[i];
  end

  // A fresh press restarts the hold at this tick, so a long event follows
  // in the same visit only when the long press time is zero.
  always_comb begin
    v_wait  = wait_r[btn_r];
    v_down  = down_r[btn_r];
    v_lg    = lg_r[btn_r];
    v_press = 1'b0;
    v_stg   = '0;
    v_k0    = bde_pkg::KIND_LONG;
    v_k1    = bde_pkg::KIND_RELEASE;
    v_k2    = bde_pkg::KIND_SHORT;
    v_hold  = hold;
    if (dueb) begin
      v_wait = 1'b0;
      if (s != v_down) begin
        if (s) begin
          v_down   = 1'b1;
          v_press  = 1'b1;
          v_hold   = '0;
          v_k0     = bde_pkg::KIND_PRESS;
          v_k1     = bde_pkg::KIND_LONG;
          v_stg[0] = 1'b1;
          v_lg     = (lpt_r == 16'd0);
          v_stg[1] = v_lg;
        end else begin
          v_down   = 1'b0;
          v_stg[0] = !v_lg && (hold >= lt);
          v_stg[1] = 1'b1;
          v_stg[2] = !(v_lg || (hold >= lt));
          v_lg     = 1'b0;
        end
      end
    end
    if (v_down && !v_lg && !v_wait && !v_press && !ld[31]) begin
      v_lg     = 1'b1;
      v_stg[0] = 1'b1;
      v_k0     = bde_pkg::KIND_LONG;
    end
  end

  bde_ram #(.WIDTH(69), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(cmd.push), .waddr(wp_r),
    .wdata({stg_b_r, k0, now_r, stg_hold_r}),
    .raddr(rp_r), .rdata(rd)
  );

  assign sts.pend     = |stg_v_r;
  assign sts.last_btn = (btn_r == BW'(BUTTONS-1));
  assign sts.empty    = (wp_r == rp_r);
  assign cur_cmd      = cmd_r;
  assign result       = {mask, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= 16'd20; lpt_r <= 16'd1000; lvl_r <= 1'b0;
      wait_r <= '0; down_r <= '0; lg_r <= '0; stg_v_r <= '0;
      wp_r <= '0; rp_r <= '0; btn_r <= '0; res_r <= '0; cmd_r <= '0;
      for (int i = 0; i < BUTTONS; i++) begin
        dl_r[i] <= '0; ps_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bde_pkg::REG_DEBOUNCE: deb_r <= cfg_data;
          bde_pkg::REG_LONG:     lpt_r <= cfg_data;
          bde_pkg::REG_LEVEL:    lvl_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        cmd_r <= in_cmd; bidx_r <= in_button; now_r <= in_now; pins_r <= in_pins;
        btn_r <= '0;
        res_r <= '0;
      end
      if (cmd.edge_arm && {29'd0, bidx_r} < BUTTONS) begin
        wait_r[BW'(bidx_r)] <= 1'b1;
        dl_r[BW'(bidx_r)] <= now_r + {16'd0, deb_r};
      end
      if (cmd.baseline) begin
        wp_r <= '0; rp_r <= '0;
        wait_r <= '0; lg_r <= '0;
        for (int i = 0; i < BUTTONS; i++) begin
          down_r[i] <= (pins_r[i] == lvl_r);
          ps_r[i] <= now_r; dl_r[i] <= '0;
        end
      end
      if (cmd.visit) begin
        stg_b_r    <= 3'(btn_r) + 3'd1;
        stg_v_r    <= v_stg;
        stg_k_r[0] <= v_k0;
        stg_k_r[1] <= v_k1;
        stg_k_r[2] <= v_k2;
        stg_hold_r <= v_hold;
        wait_r[btn_r] <= v_wait;
        down_r[btn_r] <= v_down;
        lg_r[btn_r]   <= v_lg;
        if (v_press) ps_r[btn_r] <= now_r;
      end
      if (cmd.push) begin
        wp_r <= wp_n;
        if (wp_n == rp_r) rp_r <= rp_n;
        if (stg_v_r[0]) stg_v_r[0] <= 1'b0;
        else if (stg_v_r[1]) stg_v_r[1] <= 1'b0;
        else stg_v_r[2] <= 1'b0;
      end
      if (cmd.step_btn) btn_r <= btn_r + 1'b1;
      if (cmd.pop_rd) rp_r <= rp_n;
      if (cmd.pop_out) res_r <= {rd[31:0], rd[63:32], rd[65:64], rd[68:66], 1'b1};
    end
  end
endmodule
`default_nettype wire

FILE: design/bde_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_ctrl
// Controller: handshake and sequencing of commands over buttons and pushes.
// ----------------------------------------------------------------------------
module bde_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire logic [1:0]        cur_cmd,
  input  wire bde_pkg::bde_sts_t sts,
  output bde_pkg::bde_cmd_t      cmd
);
  localparam logic [2:0] S_IDLE = 3'd0, S_DISP = 3'd1, S_VISIT = 3'd2,
                         S_PUSH = 3'd3, S_POPW = 3'd4, S_OUT = 3'd5;
  logic [2:0] state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin cmd.load = 1'b1; state_nxt = S_DISP; end
      S_DISP: begin
        unique case (cur_cmd)
          bde_pkg::CMD_EDGE:     begin cmd.edge_arm = 1'b1; state_nxt = S_OUT; end
          bde_pkg::CMD_BASELINE: begin cmd.baseline = 1'b1; state_nxt = S_OUT; end
          bde_pkg::CMD_TICK:     state_nxt = S_VISIT;
          default: if (sts.empty) state_nxt = S_OUT;
                   else begin cmd.pop_rd = 1'b1; state_nxt = S_POPW; end
        endcase
      end
      S_VISIT: begin cmd.visit = 1'b1; state_nxt = S_PUSH; end
      S_PUSH: begin
        if (sts.pend) cmd.push = 1'b1;
        else if (sts.last_btn) state_nxt = S_OUT;
        else begin cmd.step_btn = 1'b1; state_nxt = S_VISIT; end
      end
      // The ring read data is valid for exactly this one cycle.
      S_POPW: begin cmd.pop_out = 1'b1; state_nxt = S_OUT; end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

FILE: design/button_debounce_event_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_event_queue
// Multi-button debounce qualifier with press, release, short and long events.
// ----------------------------------------------------------------------------
// From the accepting cycle, edge and baseline transactions pass through the
// dispatch state to the output state; a pop of a non-empty ring adds a read wait.
// A tick visits every button in turn and pushes its staged events one at a
// time through the single ring write port before the result is offered.
// One transaction is in work at a time; the result holds until taken, and the
// next transaction is accepted in the cycle after that.
// Reset (rst_n low, synchronous) clears all button state and ring pointers
// and loads the register defaults; ring contents are not cleared.
module button_debounce_event_queue #(
  parameter int BUTTONS     = 6,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // Fields from bit 0: cmd[1:0], button_index[4:2], now_ms[36:5],
  // pin_levels at [37 +: BUTTONS], zero fill to whole bytes.
  input  wire logic [((37+BUTTONS+7)/8)*8-1:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // Fields from bit 0: event_valid[0], event_button[3:1], event_kind[5:4],
  // event_time[37:6], event_hold[69:38], held_mask[75:70], zero fill.
  output logic [79:0]      out_tdata
);
  bde_pkg::bde_cmd_t cmd;
  bde_pkg::bde_sts_t sts;
  logic [1:0]  cur_cmd;
  logic [75:0] result;

  // The controller sequences; the datapath owns all button state and the ring.
  bde_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cur_cmd(cur_cmd), .sts(sts), .cmd(cmd)
  );

  bde_datapath #(.BUTTONS(BUTTONS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_cmd(in_tdata[1:0]), .in_button(in_tdata[4:2]),
    .in_now(in_tdata[36:5]), .in_pins(in_tdata[37 +: BUTTONS]),
    .cmd(cmd), .sts(sts), .cur_cmd(cur_cmd), .result(result)
  );

  // The datapath already packs the result in output order.
  assign out_tdata = {4'd0, result};

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output both open");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.pend) else $error("push with nothing staged");
endmodule
`default_nettype wire
